@@ src/psdpt_pkg.sv @@
// Shared types and constants for the phase-shiftable dual-phase timer.
package psdpt_pkg;

    localparam int CountWidth = 16;
    localparam int IntervalWidth = 16;
    localparam int OffsetWidth = 16;
    localparam logic [IntervalWidth-1:0] IntervalReset = 16'd20000;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_SHIFT = 1'b1
    } opcode_t;

    typedef struct packed {
        logic fire_main;
        logic fire_quarter;
    } fire_t;

endpackage

@@ src/psdpt_core.sv @@
// Timer state, phase-shift bookkeeping and expiry decision for one word.
module psdpt_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [psdpt_pkg::IntervalWidth-1:0]    cfg_wr_data,
    input  logic                                   process,
    input  psdpt_pkg::opcode_t                     opcode,
    input  logic signed [psdpt_pkg::OffsetWidth-1:0] phase_offset,
    output psdpt_pkg::fire_t                       fire
);
    import psdpt_pkg::*;

    logic [IntervalWidth-1:0]      interval_reg;
    logic [CountWidth-1:0]         tick_count_reg, tick_count_next;
    logic [CountWidth-1:0]         half_period_reg, half_period_next;
    logic                          main_next_reg, main_next_next;
    logic                          restore_pending_reg, restore_pending_next;
    logic signed [OffsetWidth-1:0] pending_shift_reg, pending_shift_next;

    logic [IntervalWidth-2:0]      lim;
    logic signed [OffsetWidth:0]   req_ext;
    logic signed [OffsetWidth:0]   lim_s;
    logic signed [OffsetWidth:0]   req_clamped;
    logic signed [IntervalWidth+1:0] shift_sum;
    logic [CountWidth-1:0]         base_half;
    logic [CountWidth-1:0]         shifted_half;
    logic [CountWidth-1:0]         count_inc;
    logic                          expire;

    always_comb
    begin
        lim = interval_reg[IntervalWidth-1:1];
        base_half = CountWidth'(lim);
        req_ext = (OffsetWidth+1)'(phase_offset);
        lim_s = $signed({2'b00, lim});
        if (req_ext > lim_s)
        begin
            req_clamped = lim_s;
        end
        else if (req_ext < -lim_s)
        begin
            req_clamped = -lim_s;
        end
        else
        begin
            req_clamped = req_ext;
        end
        shift_sum = $signed({2'b00, interval_reg}) + (IntervalWidth+2)'(pending_shift_reg);
        if (shift_sum[IntervalWidth+1])
        begin
            shifted_half = '0;
        end
        else
        begin
            shifted_half = CountWidth'(shift_sum[IntervalWidth:1]);
        end
        count_inc = tick_count_reg + CountWidth'(1);
        expire = (count_inc >= half_period_reg) || (half_period_reg <= CountWidth'(1));

        tick_count_next = tick_count_reg;
        half_period_next = half_period_reg;
        main_next_next = main_next_reg;
        restore_pending_next = restore_pending_reg;
        pending_shift_next = pending_shift_reg;
        fire = '0;

        if (process)
        begin
            if (opcode == OP_SHIFT)
            begin
                pending_shift_next = OffsetWidth'(req_clamped);
            end
            else if (expire)
            begin
                tick_count_next = '0;
                main_next_next = !main_next_reg;
                if (main_next_reg)
                begin
                    fire.fire_main = 1'b1;
                    if (restore_pending_reg)
                    begin
                        half_period_next = base_half;
                        restore_pending_next = 1'b0;
                    end
                    if (pending_shift_reg != '0)
                    begin
                        half_period_next = shifted_half;
                        restore_pending_next = 1'b1;
                        pending_shift_next = '0;
                    end
                end
                else
                begin
                    fire.fire_quarter = 1'b1;
                end
            end
            else
            begin
                tick_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= IntervalReset;
            tick_count_reg <= '0;
            half_period_reg <= CountWidth'(IntervalReset[IntervalWidth-1:1]);
            main_next_reg <= 1'b0;
            restore_pending_reg <= 1'b0;
            pending_shift_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            main_next_reg <= main_next_next;
            restore_pending_reg <= restore_pending_next;
            pending_shift_reg <= pending_shift_next;
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
                half_period_reg <= CountWidth'(cfg_wr_data[IntervalWidth-1:1]);
            end
            else
            begin
                half_period_reg <= half_period_next;
            end
        end
    end

    a_fire_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire.fire_main && fire.fire_quarter))
        else $error("Main and quarter expiries fired together.");

    a_expiry_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire.fire_main || fire.fire_quarter) |=> (tick_count_reg == '0))
        else $error("Tick count not cleared after an expiry.");

    a_shift_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (process && opcode == OP_SHIFT && !cfg_wr_en)
        |=> ($stable(tick_count_reg) && $stable(main_next_reg)
             && $stable(half_period_reg)))
        else $error("Phase-shift word moved the timer.");

    a_cfg_loads_half: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (half_period_reg == CountWidth'(interval_reg[IntervalWidth-1:1])))
        else $error("Interval write did not load the base half period.");

endmodule

@@ src/phase_shiftable_dual_phase_timer_top.sv @@
// Top level of the phase-shiftable dual-phase timer with its handshake registers.
//
// Usage: each input word is either one timer tick or a phase-shift request
// carrying a signed offset. Every input word yields exactly one result word
// with fire_main and fire_quarter, which are zero for a phase-shift request.
// Expiries alternate between quarter and main events, starting with quarter.
// Both channels use valid and stall; a word moves on an edge where valid is
// high and stall is low. The interval register is written through cfg_wr_en
// and cfg_wr_data; the user must write it only while no word is in flight,
// which the block itself does not enforce. An accepted word passes through
// one input register, then the decision logic feeding the result register,
// before its result shows on the output.
// Throughput is one word per cycle while the output is not stalled, as the
// counter update and reload selection are combinational.
// Reset clears the tick count, loads the half period from an interval of
// 20000 ticks, and empties both registers. When the receiver stalls, the
// result holds, the input register fills, and then in_stall rises.
module phase_shiftable_dual_phase_timer_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [psdpt_pkg::IntervalWidth-1:0]      cfg_wr_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     opcode,
    input  logic signed [psdpt_pkg::OffsetWidth-1:0] phase_offset,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     fire_main,
    output logic                                     fire_quarter
);
    import psdpt_pkg::*;

    logic                          in_valid_reg;
    opcode_t                       opcode_reg;
    logic signed [OffsetWidth-1:0] offset_reg;
    logic                          out_valid_reg;
    fire_t                         fire_reg;
    fire_t                         fire_comb;
    logic                          advance;
    logic                          process;

    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign process = in_valid_reg && advance;

    psdpt_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .process      (process),
        .opcode       (opcode_reg),
        .phase_offset (offset_reg),
        .fire         (fire_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            opcode_reg <= opcode_t'(opcode);
            offset_reg <= phase_offset;
        end
        if (process)
        begin
            fire_reg <= fire_comb;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire_main = fire_reg.fire_main;
    assign fire_quarter = fire_reg.fire_quarter;

endmodule

@@ dv/tb_phase_shiftable_dual_phase_timer_top.sv @@
// Testbench for the phase-shiftable dual-phase timer: directed table, random phases, predictor.
module tb_phase_shiftable_dual_phase_timer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psdpt_pkg::*;

    localparam int CycleLimit = 200000;
    localparam fire_t NoFire = 2'b00;
    localparam fire_t MainFire = 2'b10;
    localparam fire_t QuarterFire = 2'b01;

    typedef struct packed {
        logic        is_cfg;
        logic [15:0] cfg_val;
        opcode_t     op;
        logic [15:0] off;
        logic        typed;
        fire_t       want;
    } step_row_t;

    localparam int DirectedRows = 31;
    localparam step_row_t DIRECTED [DirectedRows] = '{
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'h7FFF, 1'b1, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'h8000, 1'b1, NoFire},
        '{1'b1, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'hFFFF, 1'b1, QuarterFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, MainFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, QuarterFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, MainFire},
        '{1'b1, 16'd1,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, QuarterFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'h5555, 1'b1, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, MainFire},
        '{1'b1, 16'd2,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, QuarterFire},
        '{1'b1, 16'd3,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, MainFire},
        '{1'b1, 16'd65535, OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'h7FFF, 1'b1, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b1, NoFire},
        '{1'b1, 16'd65534, OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'hFFFF, 1'b1, NoFire},
        '{1'b1, 16'd4,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'h0001, 1'b1, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_TICK,  16'h0000, 1'b0, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'h0000, 1'b1, NoFire},
        '{1'b0, 16'd0,     OP_SHIFT, 16'hAAAA, 1'b1, NoFire}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [IntervalWidth-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = 1'b0;
    logic signed [OffsetWidth-1:0] phase_offset = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic fire_main;
    logic fire_quarter;

    logic [15:0] interval_now = IntervalReset;
    logic [CountWidth-1:0] ticks_seen = '0;
    logic [CountWidth-1:0] half_now = IntervalReset >> 1;
    logic main_due = 1'b0;
    logic restore_due = 1'b0;
    int shift_held = 0;

    fire_t pending_fires [$];
    int mismatches = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int hold_left = 0;
    logic pressure_done = 1'b0;
    logic quiet = 1'b0;

    phase_shiftable_dual_phase_timer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .phase_offset (phase_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fire_main    (fire_main),
        .fire_quarter (fire_quarter)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic fire_t predict_fire(input opcode_t op, input logic [15:0] off);
        fire_t fire;
        int req;
        int lim;
        int sum;
        logic [CountWidth-1:0] nxt;
        fire = NoFire;
        if (op == OP_SHIFT)
        begin
            req = int'($signed(off));
            lim = int'(interval_now >> 1);
            if (req > lim)
                req = lim;
            if (req < -lim)
                req = -lim;
            shift_held = req;
        end
        else
        begin
            nxt = ticks_seen + 1'b1;
            if (nxt >= half_now || half_now <= 1)
            begin
                ticks_seen = '0;
                if (main_due)
                begin
                    if (restore_due)
                    begin
                        half_now = interval_now >> 1;
                        restore_due = 1'b0;
                    end
                    if (shift_held != 0)
                    begin
                        sum = int'(interval_now) + shift_held;
                        if (sum < 0)
                            sum = 0;
                        half_now = CountWidth'(sum >> 1);
                        restore_due = 1'b1;
                        shift_held = 0;
                    end
                    fire = MainFire;
                end
                else
                begin
                    fire = QuarterFire;
                end
                main_due = !main_due;
            end
            else
            begin
                ticks_seen = nxt;
            end
        end
        return fire;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch at cycle %0d: %s got %b want %b", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic send_word(input opcode_t op, input logic [15:0] off, input logic typed,
                             input fire_t want);
        fire_t predicted;
        while (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        phase_offset <= off;
        predicted = predict_fire(op, off);
        pending_fires.push_back(typed ? want : predicted);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent <= words_sent + 1;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_fires.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        interval_now = value;
        half_now = value >> 1;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!pressure_done && words_sent >= 500)
        begin
            hold_left <= 80;
            pressure_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(99) < 24);
        end
    end

    always @(posedge clk)
    begin : check_results
        fire_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fires.size() == 0)
            begin
                report_mismatch("result word with nothing expected", fire_main, 1'bx);
            end
            else
            begin
                want = pending_fires.pop_front();
                if (fire_main !== want.fire_main)
                    report_mismatch("fire_main", fire_main, want.fire_main);
                if (fire_quarter !== want.fire_quarter)
                    report_mismatch("fire_quarter", fire_quarter, want.fire_quarter);
            end
        end
    end

    initial
    begin
        int p;
        int n;
        int count;
        int roll;
        logic [15:0] iv;
        logic [15:0] off;
        opcode_t op;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DirectedRows; n++)
        begin
            if (DIRECTED[n].is_cfg)
                write_interval(DIRECTED[n].cfg_val);
            else
                send_word(DIRECTED[n].op, DIRECTED[n].off, DIRECTED[n].typed,
                          DIRECTED[n].want);
        end

        for (p = 0; p < 12; p++)
        begin
            roll = $urandom_range(99);
            if (p == 0)
                iv = 16'd65534;
            else if (roll < 10)
                iv = 16'($urandom_range(0, 3));
            else if (roll < 16)
                iv = 16'($urandom_range(41, 65535));
            else
                iv = 16'($urandom_range(4, 40));
            write_interval(iv);
            quiet <= (p == 3);
            count = (p == 0) ? 40 : 115;
            for (n = 0; n < count; n++)
            begin
                op = ($urandom_range(99) < 20) ? OP_SHIFT : OP_TICK;
                if ($urandom_range(1) == 0)
                    off = 16'($urandom);
                else
                    off = 16'(int'($urandom_range(0, 60)) - 30);
                send_word(op, off, 1'b0, NoFire);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
